[rtl/assert_macros.svh]
// Assertion macros used by the top level of the cylinder clip block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/rucc_pkg.sv]
// Types, widths and constants of the unit cylinder clip pipeline.
package rucc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Fixed internal widths.
	localparam int DISC_W = 128;
	localparam int ROOT_W = DISC_W / 2;
	localparam int MAG_W  = 66;
	localparam int QUO_W  = 63;
	localparam int DEN_W  = 64;

	localparam int SQRT_LAT = ROOT_W;
	localparam int DIV_LAT  = QUO_W + 1;

	// Time limits: finite clamp and the two infinity codes.
	localparam logic [63:0] TLIM   = 64'h4000_0000_0000_0000;
	localparam logic [63:0] T_PINF = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] T_NINF = 64'h8000_0000_0000_0000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_ID       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_DENSITY  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_PRIORITY = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_MATERIAL = 8'd3;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] t_enter;
		logic signed [31:0] t_exit;
		logic [15:0]        tag_id;
		logic [31:0]        tag_density;
		logic [7:0]         tag_priority;
		logic [7:0]         tag_material;
	} hit_t;

endpackage

[rtl/rucc_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with a sideband word.
module rucc_sqrt #(
	parameter int IW  = rucc_pkg::DISC_W,
	parameter int SBW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_rad,
	input  logic [SBW-1:0]  in_sb,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [SBW-1:0]  out_sb
);
	localparam int RW  = IW / 2;
	localparam int RMW = RW + 2;

	logic [IW-1:0]  rad_s  [RW];
	logic [RMW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [SBW-1:0] sb_s   [RW];
	logic           v_s    [RW];

	for (genvar j = 0; j < RW; j++) begin : g_st
		logic [IW-1:0]  rad_in;
		logic [RMW-1:0] rem_in;
		logic [RW-1:0]  root_in;
		logic [SBW-1:0] sb_in;
		logic           v_in;
		logic [RMW+1:0] rem_sh;
		logic [RMW+1:0] trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign sb_in   = in_sb;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rad_in  = rad_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign sb_in   = sb_s[j-1];
			assign v_in    = v_s[j-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		always_comb begin
			rem_sh = {rem_in, rad_in[IW-1 -: 2]};
			trial  = {2'b00, root_in, 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			rad_s[j]  <= rad_in << 2;
			rem_s[j]  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
			root_s[j] <= {root_in[RW-2:0], ge};
			sb_s[j]   <= sb_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_in;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_sb    = sb_s[RW-1];

endmodule

[rtl/rucc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, flagging overflow on out_sat.
module rucc_div #(
	parameter int NW  = rucc_pkg::MAG_W + rucc_pkg::FRAC_BITS_DEF,
	parameter int DW  = rucc_pkg::DEN_W,
	parameter int QB  = rucc_pkg::QUO_W,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [NW-1:0]  in_num,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [QB-1:0]  out_quo,
	output logic           out_sat,
	output logic [SBW-1:0] out_sb
);
	// Head stage: quotient too wide for QB bits when the top part reaches the divisor.
	logic [DW-1:0]  hi;
	logic           sat_in;
	logic [QB-1:0]  lo_p;
	logic [DW-1:0]  rem_p;
	logic [DW-1:0]  den_p;
	logic           sat_p;
	logic [SBW-1:0] sb_p;
	logic           v_p;

	always_comb begin
		hi     = DW'(in_num[NW-1:QB]);
		sat_in = hi >= in_den;
	end

	always_ff @(posedge clk) begin
		lo_p  <= in_num[QB-1:0];
		rem_p <= sat_in ? '0 : hi;
		den_p <= in_den;
		sat_p <= sat_in;
		sb_p  <= in_sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else begin
			v_p <= in_valid;
		end
	end

	logic [QB-1:0]  lo_s  [QB];
	logic [DW-1:0]  rem_s [QB];
	logic [QB-1:0]  quo_s [QB];
	logic [DW-1:0]  den_s [QB];
	logic           sat_s [QB];
	logic [SBW-1:0] sb_s  [QB];
	logic           v_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_st
		logic [QB-1:0]  lo_in;
		logic [DW-1:0]  rem_in;
		logic [QB-1:0]  quo_in;
		logic [DW-1:0]  den_in;
		logic           sat_in_k;
		logic [SBW-1:0] sb_in;
		logic           v_in;
		logic [DW:0]    r2;
		logic           ge;

		if (k == 0) begin : g_first
			assign lo_in    = lo_p;
			assign rem_in   = rem_p;
			assign quo_in   = '0;
			assign den_in   = den_p;
			assign sat_in_k = sat_p;
			assign sb_in    = sb_p;
			assign v_in     = v_p;
		end else begin : g_next
			assign lo_in    = lo_s[k-1];
			assign rem_in   = rem_s[k-1];
			assign quo_in   = quo_s[k-1];
			assign den_in   = den_s[k-1];
			assign sat_in_k = sat_s[k-1];
			assign sb_in    = sb_s[k-1];
			assign v_in     = v_s[k-1];
		end

		// Shift in the next dividend bit and subtract where it fits.
		always_comb begin
			r2 = {rem_in, lo_in[QB-1]};
			ge = r2 >= {1'b0, den_in};
		end

		always_ff @(posedge clk) begin
			lo_s[k]  <= lo_in << 1;
			rem_s[k] <= ge ? DW'(r2 - {1'b0, den_in}) : DW'(r2);
			quo_s[k] <= {quo_in[QB-2:0], ge};
			den_s[k] <= den_in;
			sat_s[k] <= sat_in_k;
			sb_s[k]  <= sb_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_sat   = sat_s[QB-1];
	assign out_sb    = sb_s[QB-1];

endmodule

[rtl/ray_unit_cylinder_clip_top.sv]
// Top level of the capped unit cylinder clip pipeline.
// A ray taken with start comes out as a result word strobed by done.
// Throughput: one ray per clock; busy stays low and the pipeline never stalls.
// The depth is set by the 64-stage square root and the 64-stage dividers.
// Reset clears all valid bits and the object registers; results are strobed once.
module ray_unit_cylinder_clip_top #(
	parameter int FRAC_BITS = rucc_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rucc_pkg::ray_t                     ray,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rucc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	output logic                               done,
	output rucc_pkg::hit_t                     result
);
	import rucc_pkg::*;

	`include "assert_macros.svh"

	localparam int NW  = MAG_W + FRAC_BITS;
	localparam int LAT = 7 + SQRT_LAT + 1 + DIV_LAT + 4;
	localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);
	localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);

	typedef struct packed {
		logic signed [33:0] pn2;
		logic signed [33:0] pn3;
		logic [31:0]        pden;
		logic               pzero;
		logic               pin;
	} plane_t;

	typedef struct packed {
		plane_t             pl;
		logic [63:0]        a;
		logic signed [64:0] b;
		logic               az;
		logic               parin;
		logic               dneg;
	} sqsb_t;

	typedef struct packed {
		logic neg;
		logic cyl_fin;
		logic cyl_inf;
		logic pln_fin;
		logic pln_inf;
	} dsb_t;

	// Object registers.
	logic [15:0] obj_id_q;
	logic [31:0] obj_density_q;
	logic [7:0]  obj_priority_q;
	logic [7:0]  obj_material_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_id_q       <= '0;
			obj_density_q  <= '0;
			obj_priority_q <= '0;
			obj_material_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OBJECT_ID:       obj_id_q       <= cfg_data[15:0];
				CFG_OBJECT_DENSITY:  obj_density_q  <= cfg_data;
				CFG_OBJECT_PRIORITY: obj_priority_q <= cfg_data[7:0];
				CFG_OBJECT_MATERIAL: obj_material_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the front and back stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12;
	logic sq_valid;
	logic [3:0] dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= sq_valid;
			v_s9  <= dv[0];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// Stage 1: input register.
	ray_t ray_s1;

	always_ff @(posedge clk) begin
		ray_s1 <= ray;
	end

	// Stage 2: the 32x32 products and the cap plane numerators.
	logic signed [63:0] p_dxdx_s2, p_dydy_s2, p_dxsy_s2, p_dysx_s2;
	logic signed [63:0] p_dxsx_s2, p_dysy_s2, p_sxsx_s2, p_sysy_s2;
	plane_t pl_s2;
	plane_t pl_nx;
	logic signed [33:0] sz34;

	always_comb begin
		sz34 = 34'(ray_s1.src_z);
		pl_nx.pn2   = ray_s1.dir_z[31] ? sz34 - HALF : HALF - sz34;
		pl_nx.pn3   = ray_s1.dir_z[31] ? sz34 + HALF : -HALF - sz34;
		pl_nx.pden  = ray_s1.dir_z[31] ? (~ray_s1.dir_z) + 32'd1 : ray_s1.dir_z;
		pl_nx.pzero = ray_s1.dir_z == 32'sd0;
		pl_nx.pin   = (sz34 > -HALF) && (sz34 < HALF);
	end

	always_ff @(posedge clk) begin
		p_dxdx_s2 <= 64'(ray_s1.dir_x) * 64'(ray_s1.dir_x);
		p_dydy_s2 <= 64'(ray_s1.dir_y) * 64'(ray_s1.dir_y);
		p_dxsy_s2 <= 64'(ray_s1.dir_x) * 64'(ray_s1.src_y);
		p_dysx_s2 <= 64'(ray_s1.dir_y) * 64'(ray_s1.src_x);
		p_dxsx_s2 <= 64'(ray_s1.dir_x) * 64'(ray_s1.src_x);
		p_dysy_s2 <= 64'(ray_s1.dir_y) * 64'(ray_s1.src_y);
		p_sxsx_s2 <= 64'(ray_s1.src_x) * 64'(ray_s1.src_x);
		p_sysy_s2 <= 64'(ray_s1.src_y) * 64'(ray_s1.src_y);
		pl_s2     <= pl_nx;
	end

	// Stage 3: quadratic coefficients and the axis-parallel inside test.
	logic [63:0]        a_s3;
	logic [63:0]        x_s3;
	logic signed [64:0] b_s3;
	logic               parin_s3;
	plane_t             pl_s3;
	logic [63:0]        r2sum;

	always_comb begin
		r2sum = 64'(p_sxsx_s2) + 64'(p_sysy_s2);
	end

	always_ff @(posedge clk) begin
		a_s3     <= 64'(p_dxdx_s2) + 64'(p_dydy_s2);
		x_s3     <= 64'(p_dxsy_s2) - 64'(p_dysx_s2);
		b_s3     <= 65'(p_dxsx_s2) + 65'(p_dysy_s2);
		parin_s3 <= r2sum < ONE_SQ;
		pl_s3    <= pl_s2;
	end

	// Stage 4: magnitude of the cross term.
	logic [63:0]        xm_s4, a_s4;
	logic signed [64:0] b_s4;
	logic               parin_s4;
	plane_t             pl_s4;

	always_ff @(posedge clk) begin
		xm_s4    <= x_s3[63] ? (~x_s3) + 64'd1 : x_s3;
		a_s4     <= a_s3;
		b_s4     <= b_s3;
		parin_s4 <= parin_s3;
		pl_s4    <= pl_s3;
	end

	// Stage 5: partial products of the squared cross term.
	logic [63:0]        pp_ll_s5, pp_lh_s5, pp_hh_s5, a_s5;
	logic signed [64:0] b_s5;
	logic               parin_s5;
	plane_t             pl_s5;

	always_ff @(posedge clk) begin
		pp_ll_s5 <= {32'd0, xm_s4[31:0]} * {32'd0, xm_s4[31:0]};
		pp_lh_s5 <= {32'd0, xm_s4[31:0]} * {32'd0, xm_s4[63:32]};
		pp_hh_s5 <= {32'd0, xm_s4[63:32]} * {32'd0, xm_s4[63:32]};
		a_s5     <= a_s4;
		b_s5     <= b_s4;
		parin_s5 <= parin_s4;
		pl_s5    <= pl_s4;
	end

	// Stage 6: square of the cross term and the scaled squared direction length.
	logic [127:0]       xsq_s6, ashl_s6;
	logic [63:0]        a_s6;
	logic signed [64:0] b_s6;
	logic               parin_s6;
	plane_t             pl_s6;

	always_ff @(posedge clk) begin
		xsq_s6   <= {pp_hh_s5, 64'd0} + ({64'd0, pp_lh_s5} << 33) + {64'd0, pp_ll_s5};
		ashl_s6  <= {64'd0, a_s5} << (2 * FRAC_BITS);
		a_s6     <= a_s5;
		b_s6     <= b_s5;
		parin_s6 <= parin_s5;
		pl_s6    <= pl_s5;
	end

	// Stage 7: discriminant.
	logic [127:0] disc_s7;
	sqsb_t        sqsb_s7;

	always_ff @(posedge clk) begin
		disc_s7       <= ashl_s6 - xsq_s6;
		sqsb_s7.pl    <= pl_s6;
		sqsb_s7.a     <= a_s6;
		sqsb_s7.b     <= b_s6;
		sqsb_s7.az    <= a_s6 == 64'd0;
		sqsb_s7.parin <= parin_s6;
		sqsb_s7.dneg  <= ashl_s6[127] ^ xsq_s6[127] ^ 1'b0 ?
			(ashl_s6 - xsq_s6) >> 127 == 128'd1 : (ashl_s6 - xsq_s6) >> 127 == 128'd1;
	end

	// Square root of the discriminant.
	logic [ROOT_W-1:0] sq_root;
	sqsb_t             sq_sb;

	rucc_sqrt #(
		.IW  (DISC_W),
		.SBW ($bits(sqsb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.in_rad    (disc_s7),
		.in_sb     (sqsb_s7),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	// Stage 8: side and plane numerators as sign and scaled magnitude.
	logic signed [66:0] nb67, s67, num0, num1;
	logic [MAG_W-1:0]   mag0, mag1, mag2, mag3;
	logic [NW-1:0]      n_s8 [4];
	logic [DEN_W-1:0]   dside_s8, dpl_s8;
	dsb_t               dsb_s8;
	logic [3:1]         neg_s8;

	always_comb begin
		nb67 = -67'(sq_sb.b);
		s67  = $signed({3'b000, sq_root});
		num0 = nb67 - s67;
		num1 = nb67 + s67;
		mag0 = num0[66] ? MAG_W'(-num0) : MAG_W'(num0);
		mag1 = num1[66] ? MAG_W'(-num1) : MAG_W'(num1);
		mag2 = sq_sb.pl.pn2[33] ? MAG_W'(-sq_sb.pl.pn2) : MAG_W'(sq_sb.pl.pn2);
		mag3 = sq_sb.pl.pn3[33] ? MAG_W'(-sq_sb.pl.pn3) : MAG_W'(sq_sb.pl.pn3);
	end

	always_ff @(posedge clk) begin
		n_s8[0]        <= NW'(mag0) << FRAC_BITS;
		n_s8[1]        <= NW'(mag1) << FRAC_BITS;
		n_s8[2]        <= NW'(mag2) << FRAC_BITS;
		n_s8[3]        <= NW'(mag3) << FRAC_BITS;
		dside_s8       <= sq_sb.a;
		dpl_s8         <= DEN_W'(sq_sb.pl.pden);
		dsb_s8.neg     <= num0[66];
		dsb_s8.cyl_fin <= !sq_sb.dneg && !sq_sb.az;
		dsb_s8.cyl_inf <= !sq_sb.dneg && sq_sb.az && sq_sb.parin;
		dsb_s8.pln_fin <= !sq_sb.pl.pzero;
		dsb_s8.pln_inf <= sq_sb.pl.pzero && sq_sb.pl.pin;
		neg_s8[1]      <= num1[66];
		neg_s8[2]      <= sq_sb.pl.pn2[33];
		neg_s8[3]      <= sq_sb.pl.pn3[33];
	end

	// Four dividers: two side times over the squared direction length, two plane times over |dz|.
	logic [QUO_W-1:0] quo [4];
	logic [3:0]       qsat;
	dsb_t             dsb_o;
	logic [3:1]       neg_o;

	rucc_div #(
		.NW  (NW),
		.DW  (DEN_W),
		.QB  (QUO_W),
		.SBW ($bits(dsb_t))
	) u_div0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_num    (n_s8[0]),
		.in_den    (dside_s8),
		.in_sb     (dsb_s8),
		.out_valid (dv[0]),
		.out_quo   (quo[0]),
		.out_sat   (qsat[0]),
		.out_sb    (dsb_o)
	);

	for (genvar i = 1; i < 4; i++) begin : g_div
		rucc_div #(
			.NW  (NW),
			.DW  (DEN_W),
			.QB  (QUO_W),
			.SBW (1)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_s8),
			.in_num    (n_s8[i]),
			.in_den    ((i == 1) ? dside_s8 : dpl_s8),
			.in_sb     (neg_s8[i]),
			.out_valid (dv[i]),
			.out_quo   (quo[i]),
			.out_sat   (qsat[i]),
			.out_sb    (neg_o[i])
		);
	end

	// Stage 9: signed, clamped times with infinities for parallel rays.
	function automatic logic signed [63:0] tfix(input logic [QUO_W-1:0] q,
		input logic sat, input logic neg);
		logic [63:0] qf;
		qf = (sat || ({1'b0, q} > TLIM)) ? TLIM : {1'b0, q};
		return neg ? -$signed(qf) : $signed(qf);
	endfunction

	logic signed [63:0] t_s9 [4];
	logic               ok_s9;
	logic signed [63:0] tq [4];

	always_comb begin
		tq[0] = tfix(quo[0], qsat[0], dsb_o.neg);
		for (int i = 1; i < 4; i++) begin
			tq[i] = tfix(quo[i], qsat[i], neg_o[i]);
		end
	end

	always_ff @(posedge clk) begin
		t_s9[0] <= dsb_o.cyl_fin ? tq[0] : (dsb_o.cyl_inf ? T_NINF : '0);
		t_s9[1] <= dsb_o.cyl_fin ? tq[1] : (dsb_o.cyl_inf ? T_PINF : '0);
		t_s9[2] <= dsb_o.pln_fin ? tq[2] : (dsb_o.pln_inf ? T_NINF : '0);
		t_s9[3] <= dsb_o.pln_fin ? tq[3] : (dsb_o.pln_inf ? T_PINF : '0);
		ok_s9   <= (dsb_o.cyl_fin || dsb_o.cyl_inf) && (dsb_o.pln_fin || dsb_o.pln_inf);
	end

	// Stage 10: pairwise order of the four times.
	logic signed [63:0] t_s10 [4];
	logic [3:0][3:0]    gt_s10;
	logic [3:0][3:0]    gt_nx;
	logic               ok_s10;

	always_comb begin
		gt_nx = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				gt_nx[i][j] = t_s9[i] > t_s9[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		t_s10  <= t_s9;
		gt_s10 <= gt_nx;
		ok_s10 <= ok_s9;
	end

	// Stage 11: stable ranks, middle times and the hit test.
	logic [1:0]         rk [4];
	logic signed [63:0] ten_nx, tex_nx;
	logic signed [63:0] ten_s11, tex_s11;
	logic               hit_s11;

	always_comb begin
		ten_nx = '0;
		tex_nx = '0;
		for (int i = 0; i < 4; i++) begin
			rk[i] = 2'd0;
			for (int j = 0; j < 4; j++) begin
				if (j < i && !gt_s10[j][i]) begin
					rk[i] = rk[i] + 2'd1;
				end
				if (j > i && gt_s10[i][j]) begin
					rk[i] = rk[i] + 2'd1;
				end
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (rk[i] == 2'd1) begin
				ten_nx = t_s10[i];
			end
			if (rk[i] == 2'd2) begin
				tex_nx = t_s10[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		ten_s11 <= ten_nx;
		tex_s11 <= tex_nx;
		hit_s11 <= ok_s10 && !((rk[2] < 2'd2) && (rk[3] < 2'd2))
			&& !((rk[0] < 2'd2) && (rk[1] < 2'd2));
	end

	// Stage 12: saturate to 32 bits and build the result word.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	hit_t res_s12;

	always_ff @(posedge clk) begin
		if (hit_s11) begin
			res_s12.hit          <= 1'b1;
			res_s12.t_enter      <= sat32(ten_s11);
			res_s12.t_exit       <= sat32(tex_s11);
			res_s12.tag_id       <= obj_id_q;
			res_s12.tag_density  <= obj_density_q;
			res_s12.tag_priority <= obj_priority_q;
			res_s12.tag_material <= obj_material_q;
		end else begin
			res_s12 <= '0;
		end
	end

	assign done   = v_s12;
	assign result = res_s12;

	`CHK_IMPLY(a_latency, start && !busy, ##LAT done, "result word missing after pipeline latency")
	`CHK_IMPLY(a_no_orphan, done, $past(start && !busy, LAT), "result word without a ray")
	`CHK_IMPLY(a_div_align, dv[0], dv[1] && dv[2] && dv[3], "divider lanes out of step")
	`CHK_IMPLY(a_hit_order, done && result.hit, result.t_enter <= result.t_exit, "entry after exit")

endmodule

[verif/tb.sv]
// Self-checking testbench for the capped unit cylinder clip pipeline.
module tb;
	import rucc_pkg::*;

	localparam int FB       = 16;
	localparam int LATENCY  = 140;
	localparam int MAX_CYC  = 400000;
	localparam int N_RANDOM = 1430;

	// Keeps the object registers and the queue of predicted hit words.
	class clip_scoreboard;
		logic [15:0] obj_id;
		logic [31:0] obj_density;
		logic [7:0]  obj_priority;
		logic [7:0]  obj_material;
		hit_t        hits_due[$];
		int          errors;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_OBJECT_ID:       obj_id = data[15:0];
				CFG_OBJECT_DENSITY:  obj_density = data;
				CFG_OBJECT_PRIORITY: obj_priority = data[7:0];
				CFG_OBJECT_MATERIAL: obj_material = data[7:0];
				default: ;
			endcase
		endfunction

		// Floor of the square root of a nonnegative 128-bit value.
		function logic [127:0] root_floor(logic [127:0] v);
			logic [127:0] r;
			logic [127:0] c;
			r = 0;
			for (int i = 63; i >= 0; i--) begin
				c = r | (128'd1 << i);
				if (c * c <= v)
					r = c;
			end
			return r;
		endfunction

		// Scaled quotient truncated toward zero and clamped to the finite limit.
		function longint scaled_quot(logic signed [127:0] num, logic [127:0] den);
			logic [127:0] mag;
			logic [127:0] q;
			bit neg;
			if (den == 0)
				return 0;
			neg = num[127];
			mag = neg ? -num : num;
			q = (mag << FB) / den;
			if (q > 128'(TLIM))
				q = 128'(TLIM);
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'h7FFF_FFFF;
			if (v < -64'sd2147483648)
				return 32'h8000_0000;
			return v[31:0];
		endfunction

		function hit_t clip_ray(ray_t r);
			logic signed [127:0] sx, sy, sz, dx, dy, dz;
			logic signed [127:0] a, xc, xm, disc, nb, s;
			logic signed [127:0] n2, n3;
			longint t[4];
			bit     pl[4];
			longint tt;
			bit     tp, cyl, pln, in_round;
			hit_t   h;
			sx = $signed(r.src_x); sy = $signed(r.src_y); sz = $signed(r.src_z);
			dx = $signed(r.dir_x); dy = $signed(r.dir_y); dz = $signed(r.dir_z);
			t = '{0, 0, 0, 0};
			pl = '{0, 0, 1, 1};
			cyl = 0;
			pln = 0;
			h = '0;
			// Side of the cylinder.
			a = dx * dx + dy * dy;
			xc = dx * sy - dy * sx;
			xm = xc[127] ? -xc : xc;
			disc = (a << (2 * FB)) - xm * xm;
			if (!disc[127]) begin
				if (a != 0) begin
					s = root_floor(disc);
					nb = -(dx * sx + dy * sy);
					t[0] = scaled_quot(nb - s, a);
					t[1] = scaled_quot(nb + s, a);
					cyl = 1;
				end else begin
					in_round = (sx * sx + sy * sy) < (128'sd1 <<< (2 * FB));
					if (in_round) begin
						t[0] = T_NINF;
						t[1] = T_PINF;
						cyl = 1;
					end
				end
			end
			// Cap planes.
			if (dz == 0) begin
				if (sz > -(128'sd1 <<< (FB - 1)) && sz < (128'sd1 <<< (FB - 1))) begin
					t[2] = T_NINF;
					t[3] = T_PINF;
					pln = 1;
				end
			end else begin
				n2 = (128'sd1 <<< (FB - 1)) - sz;
				n3 = -(128'sd1 <<< (FB - 1)) - sz;
				if (dz < 0) begin
					n2 = -n2;
					n3 = -n3;
				end
				t[2] = scaled_quot(n2, dz < 0 ? -dz : dz);
				t[3] = scaled_quot(n3, dz < 0 ? -dz : dz);
				pln = 1;
			end
			// Stable sort; a hit needs the kinds to interleave.
			if (cyl && pln) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						if (t[j] > t[j + 1]) begin
							tt = t[j]; tp = pl[j];
							t[j] = t[j + 1]; pl[j] = pl[j + 1];
							t[j + 1] = tt; pl[j + 1] = tp;
						end
				if (!(pl[0] && pl[1] && !pl[2] && !pl[3]) &&
						!(!pl[0] && !pl[1] && pl[2] && pl[3])) begin
					h.hit = 1;
					h.t_enter = clamp32(t[1]);
					h.t_exit = clamp32(t[2]);
					h.tag_id = obj_id;
					h.tag_density = obj_density;
					h.tag_priority = obj_priority;
					h.tag_material = obj_material;
				end
			end
			return h;
		endfunction

		function void note_ray(ray_t r);
			hits_due = {hits_due, clip_ray(r)};
		endfunction

		function void check_word(hit_t got);
			hit_t want;
			if (hits_due.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			want = hits_due.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0h, got %0h", want.hit, got.hit); errors++;
			end
			if (got.t_enter !== want.t_enter) begin
				$error("t_enter: expected %0h, got %0h", want.t_enter, got.t_enter); errors++;
			end
			if (got.t_exit !== want.t_exit) begin
				$error("t_exit: expected %0h, got %0h", want.t_exit, got.t_exit); errors++;
			end
			if (got.tag_id !== want.tag_id) begin
				$error("tag_id: expected %0h, got %0h", want.tag_id, got.tag_id); errors++;
			end
			if (got.tag_density !== want.tag_density) begin
				$error("tag_density: expected %0h, got %0h", want.tag_density,
					got.tag_density);
				errors++;
			end
			if (got.tag_priority !== want.tag_priority) begin
				$error("tag_priority: expected %0h, got %0h", want.tag_priority,
					got.tag_priority);
				errors++;
			end
			if (got.tag_material !== want.tag_material) begin
				$error("tag_material: expected %0h, got %0h", want.tag_material,
					got.tag_material);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	ray_t                 ray;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 done;
	hit_t                 result;

	clip_scoreboard clip_sb;
	int             cycles;
	bit             idle_on;

	ray_unit_cylinder_clip_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ray(ray),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	// Every strobed result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done)
			clip_sb.check_word(result);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Each write starts at a falling edge after the previous one let go of valid, with random gaps while idle_on is set.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 21)
			@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		clip_sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_ray(ray_t r);
		while (idle_on && $urandom_range(99) < 21) begin
			start <= 0;
			@(negedge clk);
		end
		ray <= r;
		start <= 1;
		do @(posedge clk); while (busy);
		clip_sb.note_ray(r);
		@(negedge clk);
	endtask

	// Hold off until every predicted word has come, then let the pipe empty.
	task automatic drain();
		start <= 0;
		while (clip_sb.hits_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
	endtask

	function automatic ray_t mk_ray(int sx, int sy, int sz, int dx, int dy, int dz);
		ray_t r;
		r.src_x = sx; r.src_y = sy; r.src_z = sz;
		r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
		return r;
	endfunction

	function automatic int near_val(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Mostly rays aimed near the cylinder, with full-range noise mixed in.
	function automatic ray_t random_ray();
		ray_t r;
		int   mode;
		mode = $urandom_range(99);
		if (mode < 70)
			r = mk_ray(near_val(3 << FB), near_val(3 << FB), near_val(2 << FB),
				near_val(2 << FB), near_val(2 << FB), near_val(2 << FB));
		else if (mode < 78)
			r = mk_ray(near_val(1 << FB), near_val(1 << FB), near_val(1 << FB),
				near_val(64), near_val(64), near_val(64));
		else
			r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		case ($urandom_range(15))
			0: r.dir_z = 0;
			1: begin r.dir_x = 0; r.dir_y = 0; end
			2: begin r.dir_x = 0; r.dir_y = 0; r.dir_z = 0; end
			default: ;
		endcase
		return r;
	endfunction

	task automatic random_tags();
		write_reg(CFG_OBJECT_ID, $urandom);
		write_reg(CFG_OBJECT_DENSITY, $urandom);
		write_reg(CFG_OBJECT_PRIORITY, $urandom);
		write_reg(CFG_OBJECT_MATERIAL, $urandom);
	endtask

	localparam int ONE  = 1 << FB;
	localparam int HALF = 1 << (FB - 1);

	initial begin
		clip_sb = new();
		clk = 0;
		arst_n = 0;
		start = 0;
		ray = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 0;
		cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed rays with the tags still at their reset value.
		send_ray(mk_ray(-3 * ONE, 0, 0, ONE, 0, ONE / 16));    // plain crossing
		send_ray(mk_ray(0, 0, -2 * ONE, 0, 0, ONE));           // along the axis
		send_ray(mk_ray(2 * ONE, 0, -2 * ONE, 0, 0, ONE));     // parallel, outside
		send_ray(mk_ray(ONE, 0, 0, 0, ONE, ONE / 4));          // tangent to side
		send_ray(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0));           // parallel to caps
		send_ray(mk_ray(-3 * ONE, 0, HALF, ONE, 0, 0));        // on the cap plane
		send_ray(mk_ray(3 * ONE, 0, 0, -ONE, 0, 10 * ONE));    // caps then side
		send_ray(mk_ray(3 * ONE, 0, 0, -ONE, 0, ONE / 10));    // side then caps
		send_ray(mk_ray(0, 0, 0, 0, 0, 0));                    // no direction
		send_ray(mk_ray(0, 0, 0, 1, 0, 1));                    // huge times
		send_ray(mk_ray(3 * ONE, 3 * ONE, 0, ONE, 0, ONE));    // side miss
		send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 0,
			32'h8000_0000, 32'h7FFF_FFFF, 1));
		send_ray(mk_ray(0, 0, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF));
		send_ray(mk_ray(ONE - 1, 0, 0, 0, 0, -ONE));           // just inside radius
		drain();

		// Tag extremes, an ignored index, then random settings.
		write_reg(CFG_OBJECT_ID, 32'hFFFF_FFFF);
		write_reg(CFG_OBJECT_DENSITY, 32'hFFFF_FFFF);
		write_reg(CFG_OBJECT_PRIORITY, 32'hFFFF_FFFF);
		write_reg(CFG_OBJECT_MATERIAL, 32'hFFFF_FFFF);
		write_reg(CFG_IDX_W'(CFG_OBJECT_MATERIAL + 1), 32'h0000_0055);
		send_ray(mk_ray(-3 * ONE, 0, 0, ONE, 0, ONE / 16));
		send_ray(mk_ray(0, 0, 0, ONE, ONE, 0));
		drain();
		idle_on = 1;

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 300 == 0) begin
				drain();
				if (n == 900) begin
					write_reg(CFG_OBJECT_ID, 0);
					write_reg(CFG_OBJECT_DENSITY, 0);
					write_reg(CFG_OBJECT_PRIORITY, 0);
					write_reg(CFG_OBJECT_MATERIAL, 0);
				end else
					random_tags();
			end
			// One long stretch runs back to back.
			idle_on = !(n >= 450 && n < 750);
			send_ray(random_ray());
		end

		drain();
		if (clip_sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/rucc_pkg.sv
rtl/rucc_sqrt.sv
rtl/rucc_div.sv
rtl/ray_unit_cylinder_clip_top.sv
verif/tb.sv
